// ===== design/mhpf_pkg.sv =====
// Shared types and constants of the mail header prefix filter.
// Used by the front, the back and the top level; depends on nothing else.
package mhpf_pkg;

  // Character codes that the header parser looks for.
  localparam logic [7:0] ChCr  = 8'd13;
  localparam logic [7:0] ChSp  = 8'd32;
  localparam logic [7:0] ChTab = 8'd9;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpZ = 8'h5A;
  localparam logic [7:0] FoldDelta = 8'd32;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgFirstLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFirstHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFirstLen   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSecondLow  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSecondHigh = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSecondLen  = 3'd5;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned OffsetW  = 24;
  localparam logic [OffsetW-1:0] OffsetMax = '1;

  // A flush can cover a whole held header plus one byte, and the hold limit is at most 63.
  localparam int unsigned FlushW = 7;

  localparam int unsigned CmdDepth = 4;
  localparam int unsigned OutDepth = 4;

  // One command from the front to the back: replay held bytes, then the byte, then a marker.
  typedef struct packed {
    logic [FlushW-1:0]  flush_cnt;
    logic               emit_byte;
    logic [7:0]         data;
    logic               marker;
    logic [OffsetW-1:0] offset;
  } cmd_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               headers_done;
    logic [OffsetW-1:0] body_offset;
    logic               run_last;
  } res_t;

endpackage

// ===== design/mhpf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the bytes of headers that are not yet decided.
module mhpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mhpf_fifo.sv =====
// Small first-in first-out queue built from flip-flops.
// Stands alone; carries commands between front and back and results to the ports.
module mhpf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign count_o = count_q;

endmodule

// ===== design/mhpf_front.sv =====
// Front end: configuration registers, header parsing and prefix comparison.
// Uses mhpf_pkg; writes undecided bytes to the hold ring and issues commands to the back.
module mhpf_front #(
  parameter int unsigned HOLD_BYTES    = 15,
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mhpf_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [mhpf_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                 push_i,
  input  logic [7:0]                           in_byte_i,
  input  logic                                 message_last_i,
  output logic                                 full_o,
  output logic                                 cmd_push_o,
  output mhpf_pkg::cmd_t                       cmd_o,
  input  logic                                 cmd_full_i,
  output logic                                 ram_we_o,
  output logic [$clog2(2*HOLD_BYTES)-1:0]      ram_waddr_o,
  output logic [7:0]                           ram_wdata_o,
  input  logic [$clog2(2*HOLD_BYTES):0]        rd_ptr_i
);

  localparam int unsigned CntW  = $clog2(HOLD_BYTES + 1);
  localparam int unsigned PtrW  = $clog2(2 * HOLD_BYTES);
  localparam int unsigned Depth = 1 << PtrW;
  localparam int unsigned ExtW  = (POSITION_BITS > mhpf_pkg::OffsetW) ?
                                  POSITION_BITS : mhpf_pkg::OffsetW;

  localparam logic [1:0] PhEnv  = 2'd0;
  localparam logic [1:0] PhHdr  = 2'd1;
  localparam logic [1:0] PhDone = 2'd2;

  localparam logic [1:0] DecUnd  = 2'd0;
  localparam logic [1:0] DecKeep = 2'd1;
  localparam logic [1:0] DecDrop = 2'd2;
  localparam logic [1:0] DecNone = 2'd3;

  function automatic logic [7:0] fold_f(input logic [7:0] c);
    fold_f = (c >= mhpf_pkg::ChUpA && c <= mhpf_pkg::ChUpZ) ? c + mhpf_pkg::FoldDelta : c;
  endfunction

  function automatic logic [7:0] pchar_f(input logic [63:0] lo, input logic [63:0] hi,
                                         input logic [3:0] idx);
    pchar_f = idx[3] ? hi[{idx[2:0], 3'b000} +: 8] : lo[{idx[2:0], 3'b000} +: 8];
  endfunction

  // Configuration registers: low word, high word and length of each of the two prefixes.
  logic [63:0]                 pfx_lo_q  [2];
  logic [63:0]                 pfx_hi_q  [2];
  logic [mhpf_pkg::LenW-1:0]   pfx_len_q [2];

  // Message state.
  logic [1:0]               phase_q, phase_d;
  logic [1:0]               dec_q, dec_d;
  logic [1:0]               flags_q, flags_d;
  logic [CntW-1:0]          hcnt_q, hcnt_d;
  logic                     acr_q, acr_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [PtrW:0]            commit_q, commit_d;

  logic                     accept;
  logic [PtrW:0]            occ;
  logic                     is_cr, is_ws, new_hdr;
  logic [PtrW:0]            base;
  logic                     hb;
  logic [1:0]               hb_dec, hb_flags;
  logic [CntW-1:0]          hb_n;
  logic [7:0]               n8;
  logic [1:0]               hit, clr, flags_new;
  logic [CntW-1:0]          pre_cnt, kfl_cnt, lfl_cnt;
  logic                     emit_b, marker, hold_wr;
  logic [POSITION_BITS-1:0] mk_pos;
  logic [ExtW-1:0]          mk_ext;
  logic [mhpf_pkg::FlushW-1:0] flush_tot;

  assign accept = push_i && !full_o;
  assign occ    = commit_q + (PtrW+1)'(hcnt_q) - rd_ptr_i;
  assign full_o = cmd_full_i || occ[PtrW];

  assign is_cr   = (in_byte_i == mhpf_pkg::ChCr);
  assign is_ws   = (in_byte_i == mhpf_pkg::ChSp) || (in_byte_i == mhpf_pkg::ChTab);
  assign new_hdr = (dec_q == DecNone) || (acr_q && !is_ws);
  assign n8      = 8'(hb_n);

  // Both prefix compares of the current byte against character hb_n.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      logic [7:0] len8;
      logic       eq;
      len8   = 8'(pfx_len_q[k]);
      eq     = fold_f(pchar_f(pfx_lo_q[k], pfx_hi_q[k], n8[3:0])) == fold_f(in_byte_i);
      hit[k] = hb_flags[k] && ((n8 >= len8) || (eq && (n8 + 8'd1 == len8)));
      clr[k] = hb_flags[k] && !(n8 >= len8) && !eq;
    end
    flags_new = hb_flags & ~clr;
  end

  always_comb begin
    phase_d  = phase_q;
    dec_d    = dec_q;
    flags_d  = flags_q;
    hcnt_d   = hcnt_q;
    acr_d    = acr_q;
    commit_d = commit_q;
    pos_d    = (pos_q == '1) ? pos_q : pos_q + POSITION_BITS'(1);
    pre_cnt  = '0;
    kfl_cnt  = '0;
    lfl_cnt  = '0;
    hb       = 1'b0;
    hb_dec   = dec_q;
    hb_flags = flags_q;
    hb_n     = hcnt_q;
    emit_b   = 1'b0;
    marker   = 1'b0;
    hold_wr  = 1'b0;
    mk_pos   = pos_q;
    base     = commit_q;

    unique case (phase_q)
      PhEnv: begin
        // The envelope line ends at the first CR after the very first byte.
        if (pos_q != '0 && is_cr) begin
          phase_d = PhHdr;
          dec_d   = DecNone;
          acr_d   = 1'b0;
        end
      end
      PhHdr: begin
        // Closing an undecided header replays what it held.
        if (dec_q != DecNone && new_hdr && dec_q == DecUnd) begin
          pre_cnt = hcnt_q;
        end
        base     = commit_q + (PtrW+1)'(pre_cnt);
        commit_d = base;
        if (new_hdr) begin
          hcnt_d = '0;
          acr_d  = 1'b0;
          if (is_cr) begin
            marker  = 1'b1;
            mk_pos  = pos_q;
            phase_d = PhDone;
            dec_d   = DecNone;
          end else begin
            hb       = 1'b1;
            hb_dec   = DecUnd;
            hb_flags = 2'b11;
            hb_n     = '0;
            flags_d  = 2'b11;
          end
        end else begin
          hb    = 1'b1;
          acr_d = is_cr;
        end
      end
      PhDone: begin
      end
      default: begin
      end
    endcase

    if (hb) begin
      unique case (hb_dec)
        DecKeep: begin
          emit_b = 1'b1;
        end
        DecUnd: begin
          if (|hit) begin
            dec_d  = DecDrop;
            hcnt_d = '0;
          end else if (flags_new == 2'b00 || hb_n >= CntW'(HOLD_BYTES)) begin
            kfl_cnt  = hb_n;
            emit_b   = 1'b1;
            dec_d    = DecKeep;
            hcnt_d   = '0;
            commit_d = base + (PtrW+1)'(hb_n);
          end else begin
            hold_wr = 1'b1;
            dec_d   = DecUnd;
            flags_d = flags_new;
            hcnt_d  = hb_n + CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    if (message_last_i) begin
      if (phase_d == PhHdr) begin
        if (dec_d == DecUnd) begin
          lfl_cnt  = hcnt_d;
          commit_d = commit_d + (PtrW+1)'(hcnt_d);
        end
        marker = 1'b1;
        mk_pos = pos_d;
      end else if (phase_d == PhEnv) begin
        marker = 1'b1;
        mk_pos = pos_d;
      end
      phase_d = PhEnv;
      dec_d   = DecUnd;
      flags_d = 2'b11;
      hcnt_d  = '0;
      acr_d   = 1'b0;
      pos_d   = '0;
    end
  end

  assign flush_tot = mhpf_pkg::FlushW'(pre_cnt) + mhpf_pkg::FlushW'(kfl_cnt) +
                     mhpf_pkg::FlushW'(lfl_cnt);
  assign mk_ext    = ExtW'(mk_pos);

  assign cmd_push_o       = accept && (flush_tot != '0 || emit_b || marker);
  assign cmd_o.flush_cnt  = flush_tot;
  assign cmd_o.emit_byte  = emit_b;
  assign cmd_o.data       = in_byte_i;
  assign cmd_o.marker     = marker;
  assign cmd_o.offset     = (mk_ext > ExtW'(mhpf_pkg::OffsetMax)) ? mhpf_pkg::OffsetMax :
                            mk_ext[mhpf_pkg::OffsetW-1:0];

  assign ram_we_o    = accept && hold_wr;
  assign ram_waddr_o = PtrW'(base + (PtrW+1)'(hb_n));
  assign ram_wdata_o = in_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 2; k++) begin
        pfx_lo_q[k]  <= '0;
        pfx_hi_q[k]  <= '0;
        pfx_len_q[k] <= '1;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mhpf_pkg::CfgFirstLow:   pfx_lo_q[0]  <= cfg_wdata_i;
        mhpf_pkg::CfgFirstHigh:  pfx_hi_q[0]  <= cfg_wdata_i;
        mhpf_pkg::CfgFirstLen:   pfx_len_q[0] <= cfg_wdata_i[mhpf_pkg::LenW-1:0];
        mhpf_pkg::CfgSecondLow:  pfx_lo_q[1]  <= cfg_wdata_i;
        mhpf_pkg::CfgSecondHigh: pfx_hi_q[1]  <= cfg_wdata_i;
        mhpf_pkg::CfgSecondLen:  pfx_len_q[1] <= cfg_wdata_i[mhpf_pkg::LenW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhEnv;
      dec_q    <= DecUnd;
      flags_q  <= 2'b11;
      hcnt_q   <= '0;
      acr_q    <= 1'b0;
      pos_q    <= '0;
      commit_q <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      dec_q    <= dec_d;
      flags_q  <= flags_d;
      hcnt_q   <= hcnt_d;
      acr_q    <= acr_d;
      pos_q    <= pos_d;
      commit_q <= commit_d;
    end
  end

`ifndef SYNTHESIS
  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= (PtrW+1)'(Depth))
    else $error("hold ring occupancy exceeds its depth");

  a_hold_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= CntW'(HOLD_BYTES))
    else $error("hold count exceeds the hold limit");

  a_hold_undecided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q != '0 |-> (dec_q == DecUnd && phase_q == PhHdr))
    else $error("bytes held outside an undecided header");
`endif

endmodule

// ===== design/mhpf_back.sv =====
// Back end: expands commands into results, replaying held bytes from the hold ring.
// Uses mhpf_pkg and mhpf_fifo; reads the hold ring through a registered RAM port.
module mhpf_back #(
  parameter int unsigned HOLD_BYTES = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_empty_i,
  input  mhpf_pkg::cmd_t                  cmd_i,
  output logic                            cmd_pop_o,
  output logic                            ram_re_o,
  output logic [$clog2(2*HOLD_BYTES)-1:0] ram_raddr_o,
  input  logic [7:0]                      ram_rdata_i,
  output logic [$clog2(2*HOLD_BYTES):0]   rd_ptr_o,
  output logic                            res_empty_o,
  input  logic                            res_pop_i,
  output mhpf_pkg::res_t                  res_o
);

  localparam int unsigned PtrW = $clog2(2 * HOLD_BYTES);
  localparam int unsigned OCW  = $clog2(mhpf_pkg::OutDepth + 1);

  logic [mhpf_pkg::FlushW-1:0]  fl_q;
  logic                         bdone_q;
  logic [PtrW:0]                rd_ptr_q;

  // Second stage: one result, its byte possibly still arriving from the RAM.
  logic                         v_q;
  logic                         src_ram_q;
  logic                         mk_q;
  logic                         last_q;
  logic [7:0]                   byte_q;
  logic [mhpf_pkg::OffsetW-1:0] off_q;

  logic           credit, go, fl_more, is_byte, is_last;
  logic           out_full;
  logic [OCW-1:0] out_count;
  mhpf_pkg::res_t res_in;

  assign credit  = ({1'b0, out_count} + (OCW+1)'(v_q)) < (OCW+1)'(mhpf_pkg::OutDepth);
  assign go      = !cmd_empty_i && credit;
  assign fl_more = fl_q < cmd_i.flush_cnt;
  assign is_byte = !fl_more && cmd_i.emit_byte && !bdone_q;

  always_comb begin
    if (fl_more) begin
      is_last = (fl_q + mhpf_pkg::FlushW'(1) == cmd_i.flush_cnt) &&
                !cmd_i.emit_byte && !cmd_i.marker;
    end else if (is_byte) begin
      is_last = !cmd_i.marker;
    end else begin
      is_last = 1'b1;
    end
  end

  assign cmd_pop_o   = go && is_last;
  assign ram_re_o    = go && fl_more;
  assign ram_raddr_o = rd_ptr_q[PtrW-1:0];
  assign rd_ptr_o    = rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_q     <= '0;
      bdone_q  <= 1'b0;
      rd_ptr_q <= '0;
      v_q      <= 1'b0;
    end else begin
      v_q <= go;
      if (go) begin
        if (is_last) begin
          fl_q    <= '0;
          bdone_q <= 1'b0;
        end else if (fl_more) begin
          fl_q <= fl_q + mhpf_pkg::FlushW'(1);
        end else begin
          bdone_q <= 1'b1;
        end
        if (fl_more) begin
          rd_ptr_q <= rd_ptr_q + (PtrW+1)'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      src_ram_q <= fl_more;
      mk_q      <= !fl_more && !is_byte;
      last_q    <= is_last;
      byte_q    <= is_byte ? cmd_i.data : 8'd0;
      off_q     <= cmd_i.offset;
    end
  end

  assign res_in.out_byte     = src_ram_q ? ram_rdata_i : byte_q;
  assign res_in.byte_valid   = !mk_q;
  assign res_in.headers_done = mk_q;
  assign res_in.body_offset  = mk_q ? off_q : '0;
  assign res_in.run_last     = last_q;

  mhpf_fifo #(
    .WIDTH ($bits(mhpf_pkg::res_t)),
    .DEPTH (mhpf_pkg::OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (v_q),
    .wdata_i (res_in),
    .pop_i   (res_pop_i),
    .rdata_o (res_o),
    .empty_o (res_empty_o),
    .full_o  (out_full),
    .count_o (out_count)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> !out_full)
    else $error("result written into a full output queue");

  a_flush_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (fl_q == cmd_i.flush_cnt || fl_q + mhpf_pkg::FlushW'(1) == cmd_i.flush_cnt))
    else $error("command retired before all held bytes were replayed");

  a_ptr_moves_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ram_re_o |=> $stable(rd_ptr_q))
    else $error("read pointer moved without a RAM read");
`endif

endmodule

// ===== design/mail_header_prefix_filter.sv =====
// Top level of the mail header prefix filter: front, command queue, hold ring and back.
// Uses mhpf_pkg, mhpf_front, mhpf_fifo, mhpf_ram and mhpf_back.
//
//  Channel   Signals                                   Request moved when
//  -------   ---------------------------------------   -----------------------------
//  input     push, full, in_byte_i, message_last_i     push high and full low
//  result    empty, pop, out_byte_o .. run_last_o      pop high and empty low
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i          cfg_we_i high
//
// The block takes one byte request per cycle while full is low and gives at most one result per cycle.
// Between a byte and the result that it causes, the command queue, the replay
// sequencer and the output queue each add one register.
// Held bytes of an undecided header are replayed from the hold ring at one per cycle while the output queue has room;
// they were taken in one per cycle earlier, so replay does not lower the sustained rate.
// The input reports full when the command queue is full or the hold ring has no room.
// Reset is asynchronous and active low; no clearing pass follows it.
module mail_header_prefix_filter #(
  parameter int unsigned HOLD_BYTES    = 15,
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mhpf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mhpf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte_i,
  input  logic                          message_last_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte_o,
  output logic                          byte_valid_o,
  output logic                          headers_done_o,
  output logic [mhpf_pkg::OffsetW-1:0]  body_offset_o,
  output logic                          run_last_o
);

  // The hold ring has room for two held headers, so the front can keep filling
  // one header while the back is still replaying the previous one.
  localparam int unsigned PtrW  = $clog2(2 * HOLD_BYTES);
  localparam int unsigned Depth = 1 << PtrW;

  mhpf_pkg::cmd_t  cmd_in, cmd_out;
  mhpf_pkg::res_t  res;
  logic            cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic            ram_we, ram_re;
  logic [PtrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;
  logic [PtrW:0]   rd_ptr;

  // The front parses each byte in the cycle it is taken and issues at most one command.
  mhpf_front #(
    .HOLD_BYTES    (HOLD_BYTES),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push_i         (push),
    .in_byte_i      (in_byte_i),
    .message_last_i (message_last_i),
    .full_o         (full),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in),
    .cmd_full_i     (cmd_full),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .rd_ptr_i       (rd_ptr)
  );

  // Commands wait here so that a stalled result side does not stop parsing at once.
  mhpf_fifo #(
    .WIDTH ($bits(mhpf_pkg::cmd_t)),
    .DEPTH (mhpf_pkg::CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty),
    .full_o  (cmd_full),
    .count_o ()
  );

  // Bytes of headers whose prefix compare is still open.
  mhpf_ram #(
    .WIDTH (8),
    .DEPTH (Depth)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The back turns each command into replayed bytes, the current byte and a marker.
  mhpf_back #(
    .HOLD_BYTES (HOLD_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .rd_ptr_o    (rd_ptr),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (res)
  );

  assign out_byte_o     = res.out_byte;
  assign byte_valid_o   = res.byte_valid;
  assign headers_done_o = res.headers_done;
  assign body_offset_o  = res.body_offset;
  assign run_last_o     = res.run_last;

endmodule
